// ===== src/zero_crossing_cycle_replay_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the zero-crossing cycle replay core
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ZERO_CROSSING_CYCLE_REPLAY_CORE_MACROS_SVH
`define ZERO_CROSSING_CYCLE_REPLAY_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ZCCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ZCCR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/zccr_pkg.sv =====
// ----------------------------------------------------------------------------
// zccr_pkg
// Constants, codes and shared types of the zero-crossing cycle replay core.
// ----------------------------------------------------------------------------
package zccr_pkg;

  localparam int CYCLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(CYCLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;

  localparam int SMP_W  = 16;
  localparam int GAIN_W = 16;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'h8000;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_GAIN = 1'b1;

  typedef enum logic {
    MODE_CAPTURE = 1'b0,
    MODE_REPLAY  = 1'b1
  } zccr_mode_t;

  // Request leaving the memory stage towards the mixer.
  typedef struct packed {
    logic                    valid;
    logic                    replaying;
    logic signed [SMP_W-1:0] sample;
    logic signed [SMP_W-1:0] stored;
  } zccr_s1_t;

endpackage

// ===== src/zccr_if.sv =====
// ----------------------------------------------------------------------------
// zccr channel interfaces
// Valid/ready channels for input samples and mixed results.
// ----------------------------------------------------------------------------
interface zccr_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [zccr_pkg::SMP_W-1:0]         in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

interface zccr_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [zccr_pkg::SMP_W-1:0]         out_sample;
  logic                                      replaying;

  modport source (output valid, output out_sample, output replaying, input ready);
  modport sink   (input valid, input out_sample, input replaying, output ready);
endinterface

// ===== src/zccr_capture.sv =====
// ----------------------------------------------------------------------------
// zccr_capture
// Crossing detection, capture/replay control and the cycle memory.
// ----------------------------------------------------------------------------
`include "zero_crossing_cycle_replay_core_macros.svh"

module zccr_capture (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [zccr_pkg::SMP_W-1:0] in_sample,
  output logic                              in_ready,
  input  logic                              s2_ready,
  output zccr_pkg::zccr_s1_t                s1
);

  localparam logic [zccr_pkg::CNT_W-1:0] DEPTH_C = zccr_pkg::CNT_W'(zccr_pkg::CYCLE_DEPTH);

  zccr_pkg::zccr_mode_t mode_r, mode_nxt;
  logic [zccr_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [zccr_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic                        prev_neg_r;

  logic                        v1_r, v1_nxt;
  logic                        rep1_r;
  logic                        guard1_r;
  logic signed [zccr_pkg::SMP_W-1:0] smp1_r;
  logic signed [zccr_pkg::SMP_W-1:0] mem_q_r;

  logic signed [zccr_pkg::SMP_W-1:0] mem [zccr_pkg::CYCLE_DEPTH];

  logic                        accept;
  logic                        rising;
  logic                        rd_ok;
  logic [zccr_pkg::CNT_W-1:0]  cnt_inc;
  logic [zccr_pkg::CNT_W-1:0]  idx_inc;
  logic                        we;
  logic                        re;
  logic [zccr_pkg::ADDR_W-1:0] waddr;
  logic signed [zccr_pkg::SMP_W-1:0] wdata;

  assign in_ready = !v1_r || s2_ready;
  assign accept   = in_valid && in_ready;
  assign rising   = prev_neg_r && !in_sample[zccr_pkg::SMP_W-1];
  assign cnt_inc  = cnt_r + 1'b1;
  assign idx_inc  = idx_r + 1'b1;
  assign rd_ok    = (idx_r < cnt_r) && (idx_r < DEPTH_C);

  // Next mode.
  always_comb begin
    mode_nxt = mode_r;
    if (accept) begin
      case (mode_r)
        zccr_pkg::MODE_CAPTURE: begin
          if (cnt_r >= DEPTH_C) begin
            mode_nxt = zccr_pkg::MODE_REPLAY;
          end else if (cnt_r != '0 && (rising || cnt_inc >= DEPTH_C)) begin
            mode_nxt = zccr_pkg::MODE_REPLAY;
          end
        end
        zccr_pkg::MODE_REPLAY: begin
          if (idx_inc >= cnt_r) begin
            mode_nxt = zccr_pkg::MODE_CAPTURE;
          end
        end
        default: mode_nxt = zccr_pkg::MODE_CAPTURE;
      endcase
    end
  end

  // Memory accesses and counters for the accepted request.
  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = cnt_r[zccr_pkg::ADDR_W-1:0];
    wdata   = in_sample;
    if (accept) begin
      case (mode_r)
        zccr_pkg::MODE_CAPTURE: begin
          if (cnt_r == '0) begin
            if (rising) begin
              we      = 1'b1;
              cnt_nxt = zccr_pkg::CNT_W'(1);
            end
          end else if (cnt_r < DEPTH_C) begin
            // The closing crossing itself is stored as silence.
            we      = 1'b1;
            wdata   = rising ? '0 : in_sample;
            cnt_nxt = cnt_inc;
          end
        end
        zccr_pkg::MODE_REPLAY: begin
          re      = rd_ok;
          idx_nxt = idx_inc;
          if (idx_inc >= cnt_r) begin
            cnt_nxt = '0;
            idx_nxt = '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign v1_nxt = accept ? 1'b1 : (s2_ready ? 1'b0 : v1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= zccr_pkg::MODE_CAPTURE;
      cnt_r      <= '0;
      idx_r      <= '0;
      prev_neg_r <= 1'b0;
      v1_r       <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      idx_r  <= idx_nxt;
      v1_r   <= v1_nxt;
      if (accept) begin
        prev_neg_r <= in_sample[zccr_pkg::SMP_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp1_r   <= in_sample;
      rep1_r   <= (mode_r == zccr_pkg::MODE_REPLAY);
      guard1_r <= (mode_r == zccr_pkg::MODE_REPLAY) && rd_ok;
    end
  end

  // Each request either writes or reads, never both, so the same entry is
  // never touched twice at one edge and no bypass is needed.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q_r <= mem[idx_r[zccr_pkg::ADDR_W-1:0]];
    end
  end

  assign s1.valid     = v1_r;
  assign s1.replaying = rep1_r;
  assign s1.sample    = smp1_r;
  assign s1.stored    = guard1_r ? mem_q_r : '0;

  `ZCCR_ASSERT_IMP(a_replay_has_cycle, mode_r == zccr_pkg::MODE_REPLAY, cnt_r != '0, "replay with empty cycle")
  `ZCCR_ASSERT_IMP(a_index_in_cycle, mode_r == zccr_pkg::MODE_REPLAY, idx_r < cnt_r, "replay index past cycle end")
  `ZCCR_ASSERT_NXT(a_stage_holds, v1_r && !s2_ready, v1_r && $stable(smp1_r) && $stable(s1.stored), "memory stage lost a stalled request")

endmodule

// ===== src/zccr_mix.sv =====
// ----------------------------------------------------------------------------
// zccr_mix
// Gain registers, product stage, rounding, saturation and output register.
// ----------------------------------------------------------------------------
`include "zero_crossing_cycle_replay_core_macros.svh"

module zccr_mix (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  zccr_pkg::zccr_s1_t                    s1,
  output logic                                  s2_ready,
  input  logic                                  cfg_we,
  input  logic [zccr_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [zccr_pkg::CFG_W-1:0]            cfg_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [zccr_pkg::SMP_W-1:0]     out_sample,
  output logic                                  replaying
);

  localparam int PROD_W = 2 * zccr_pkg::SMP_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = SUM_W - 15;

  logic [zccr_pkg::GAIN_W-1:0] gain_in_r, gain_cy_r;

  logic                        v2_r, v2_nxt;
  logic                        rep2_r;
  logic signed [PROD_W-1:0]    pin2_r, pcy2_r;
  logic                        ov_r, ov_nxt;
  logic signed [zccr_pkg::SMP_W-1:0] osmp_r, osmp_nxt;
  logic                        orep_r;

  logic                        out_adv;
  logic signed [SUM_W-1:0]     pin_full, pcy_full;
  logic signed [SUM_W-1:0]     sum;
  logic signed [RND_W-1:0]     rnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_in_r <= zccr_pkg::GAIN_UNITY;
      gain_cy_r <= zccr_pkg::GAIN_UNITY;
    end else if (cfg_we) begin
      case (cfg_idx)
        zccr_pkg::REG_INPUT_GAIN: gain_in_r <= cfg_data;
        zccr_pkg::REG_CYCLE_GAIN: gain_cy_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_adv  = !ov_r || out_ready;
  assign s2_ready = !v2_r || out_adv;
  assign v2_nxt   = s2_ready ? s1.valid : v2_r;
  assign ov_nxt   = out_adv ? v2_r : ov_r;

  // Gains are unsigned, so they enter the signed multiply with a zero on top.
  assign pin_full = SUM_W'(s1.sample) * $signed({1'b0, gain_in_r});
  assign pcy_full = SUM_W'(s1.stored) * $signed({1'b0, gain_cy_r});

  // Round half up by adding half an LSB and taking the floor shift.
  assign sum = SUM_W'(pin2_r) + SUM_W'(pcy2_r) + SUM_W'(16384);
  assign rnd = sum[SUM_W-1:15];

  always_comb begin
    if (rnd > RND_W'(32767)) begin
      osmp_nxt = 16'sh7FFF;
    end else if (rnd < -RND_W'(32768)) begin
      osmp_nxt = 16'sh8000;
    end else begin
      osmp_nxt = rnd[zccr_pkg::SMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v2_r <= v2_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1.valid) begin
      pin2_r <= pin_full[PROD_W-1:0];
      pcy2_r <= pcy_full[PROD_W-1:0];
      rep2_r <= s1.replaying;
    end
    if (out_adv && v2_r) begin
      osmp_r <= osmp_nxt;
      orep_r <= rep2_r;
    end
  end

  assign out_valid  = ov_r;
  assign out_sample = osmp_r;
  assign replaying  = orep_r;

  `ZCCR_ASSERT_IMP(a_dry_only_capture, v2_r && !rep2_r, pcy2_r == '0, "cycle term present in capture")
  `ZCCR_ASSERT_NXT(a_prod_holds, v2_r && !out_adv, v2_r && $stable(pin2_r) && $stable(pcy2_r), "product stage lost a stalled request")
  `ZCCR_ASSERT_NXT(a_out_fed, v2_r && out_adv, ov_r, "product stage did not reach the output register")

endmodule

// ===== src/zero_crossing_cycle_replay_core.sv =====
// Requests pass the memory stage, product stage and output register in turn.
// Throughput: one sample per cycle unless the result side stalls; the cycle memory does
// at most one read or one write per request. Stalls on the result side back up through
// the pipeline stage by stage. Reset clears mode, counters and pipeline valids and sets
// both gains to 1.0; the cycle memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// zero_crossing_cycle_replay_core
// Captures one waveform cycle between rising zero crossings and mixes its replay
// with the dry input.
// ----------------------------------------------------------------------------
module zero_crossing_cycle_replay_core (
  input  logic                                clk,
  input  logic                                rst_n,
  zccr_in_if.sink                             in_ch,
  zccr_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [zccr_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [zccr_pkg::CFG_W-1:0]          cfg_data
);

  zccr_pkg::zccr_s1_t s1;
  logic               s2_ready;
  logic               in_ready;

  assign in_ch.ready = in_ready;

  zccr_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_sample (in_ch.in_sample),
    .in_ready  (in_ready),
    .s2_ready  (s2_ready),
    .s1        (s1)
  );

  zccr_mix u_mix (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1         (s1),
    .s2_ready   (s2_ready),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_sample (out_ch.out_sample),
    .replaying  (out_ch.replaying)
  );

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the zero-crossing cycle replay core. It streams mono
// samples through the valid/ready channels under random bursts and stalls. A
// request-level model of capture and replay predicts each mixed sample, and each
// result is checked against that prediction in order.
// ----------------------------------------------------------------------------
module tb;
  import zccr_pkg::*;

  typedef struct packed {
    logic signed [SMP_W-1:0] smp;
    logic                    replaying;
  } mix_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  zccr_in_if  in_ch ();
  zccr_out_if out_ch ();

  zero_crossing_cycle_replay_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Model state of the core.
  logic signed [SMP_W-1:0] cyc_mem [CYCLE_DEPTH];
  int                      cap_count;
  int                      rep_idx;
  zccr_mode_t              mode;
  logic signed [SMP_W-1:0] prev_smp;
  logic [GAIN_W-1:0]       in_gain;
  logic [GAIN_W-1:0]       cyc_gain;

  mix_result_t expected_mix [$];
  mix_result_t want_mix;

  // Stimulus and stall controls.
  int burst_left;
  int gap_max;
  int stall_pct;
  int stall_run;
  int hold_req;
  int hold_left;

  // Tallies.
  int n_errors;
  int n_requests;
  int n_results;
  int n_replayed;
  int n_cycles;
  int n_fills;
  int n_sat;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** zero_crossing_cycle_replay_core: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    n_errors++;
    if (n_errors <= 50)
      $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic logic signed [SMP_W-1:0] round_q15(input longint acc);
    longint r;
    r = (acc + 64'sd16384) >>> 15;
    if (r > 32767) begin
      r = 32767;
      n_sat++;
    end else if (r < -32768) begin
      r = -32768;
      n_sat++;
    end
    return r[SMP_W-1:0];
  endfunction

  // Advances the model by one input request and returns the mixed sample it yields.
  function automatic mix_result_t mix_predict(input logic signed [SMP_W-1:0] cur);
    longint      acc;
    longint      stored;
    logic        rising;
    mix_result_t res;
    rising = (prev_smp < 0) && (cur >= 0);
    acc = longint'(cur) * longint'(in_gain);
    if (mode == MODE_CAPTURE) begin
      if (cap_count == 0) begin
        if (rising) begin
          cyc_mem[0] = cur;
          cap_count = 1;
        end
      end else if (cap_count < CYCLE_DEPTH) begin
        if (!rising) begin
          cyc_mem[cap_count] = cur;
          cap_count++;
          if (cap_count >= CYCLE_DEPTH) begin
            mode = MODE_REPLAY;
            n_fills++;
            n_cycles++;
          end
        end else begin
          // The closing crossing is replaced by a stored zero.
          cyc_mem[cap_count] = '0;
          cap_count++;
          mode = MODE_REPLAY;
          n_cycles++;
        end
      end else begin
        mode = MODE_REPLAY;
      end
      res.replaying = 1'b0;
    end else begin
      stored = 0;
      if (rep_idx < cap_count && rep_idx < CYCLE_DEPTH)
        stored = longint'(cyc_mem[rep_idx]);
      acc += stored * longint'(cyc_gain);
      rep_idx++;
      if (rep_idx >= cap_count) begin
        cap_count = 0;
        rep_idx = 0;
        mode = MODE_CAPTURE;
      end
      res.replaying = 1'b1;
    end
    res.smp = round_q15(acc);
    prev_smp = cur;
    return res;
  endfunction

  function automatic logic signed [SMP_W-1:0] rand_any();
    return SMP_W'($urandom_range(65535, 0));
  endfunction

  function automatic logic signed [SMP_W-1:0] rand_neg();
    int r;
    r = $urandom_range(15, 0);
    if (r == 0) return -16'sd1;
    if (r == 1) return -16'sd32768;
    return SMP_W'(-int'($urandom_range(32768, 1)));
  endfunction

  function automatic logic signed [SMP_W-1:0] rand_pos();
    int r;
    r = $urandom_range(15, 0);
    if (r == 0) return 16'sd0;
    if (r == 1) return 16'sd32767;
    return SMP_W'($urandom_range(32767, 0));
  endfunction

  // Offers one sample and waits until the core takes it. Valid is left high so
  // that back-to-back requests need no second assignment in the same step.
  task automatic send_sample(input logic signed [SMP_W-1:0] s);
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      if (gap_max > 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(gap_max, 1)) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.in_sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_requests++;
    expected_mix.push_back(mix_predict(s));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_mix.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_gains(input logic [GAIN_W-1:0] ig, input logic [GAIN_W-1:0] cg);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_INPUT_GAIN;
    cfg_data <= ig;
    @(posedge clk);
    in_gain = ig;
    cfg_idx  <= REG_CYCLE_GAIN;
    cfg_data <= cg;
    @(posedge clk);
    cyc_gain = cg;
    cfg_we <= 1'b0;
  endtask

  // Mostly whole waveform cycles (a negative run, then a non-negative run) with
  // random content, mixed with isolated noise samples.
  task automatic run_wave(input int n_items);
    int sent;
    int neg_len;
    int pos_len;
    int max_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99, 0) < 15) begin
        send_sample(rand_any());
        sent++;
      end else begin
        max_len = ($urandom_range(9, 0) == 0) ? 64 : 10;
        neg_len = $urandom_range(max_len, 1);
        pos_len = $urandom_range(max_len, 1);
        repeat (neg_len) begin
          send_sample(rand_neg());
          sent++;
        end
        repeat (pos_len) begin
          send_sample(rand_pos());
          sent++;
        end
      end
    end
  endtask

  // Brings the core back to capture mode with nothing stored.
  task automatic settle_to_capture();
    while (!(mode == MODE_CAPTURE && cap_count == 0))
      send_sample((prev_smp < 0) ? 16'sd100 : -16'sd100);
  endtask

  // The first sample after reset cannot cross; a short cycle with extreme values
  // is then captured, closed by a crossing and replayed with saturation.
  task automatic test_directed_extremes();
    logic signed [SMP_W-1:0] seq [15];
    seq = '{16'sd0, 16'sd32767, -16'sd1, 16'sd0, 16'sd32767, -16'sd32768, -16'sd32768,
            16'sd1, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767, 16'sd0,
            -16'sd32768, 16'sd32767};
    stall_pct = 20;
    gap_max   = 3;
    foreach (seq[k]) send_sample(seq[k]);
    drain_results();
  endtask

  task automatic test_gain_sweep();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_gains(GAIN_UNITY, GAIN_UNITY);
        1: set_gains(16'd0, 16'd0);
        2: set_gains(16'hFFFF, 16'hFFFF);
        3: set_gains(GAIN_UNITY, 16'd0);
        4: set_gains(16'd0, 16'hFFFF);
        default: set_gains(GAIN_W'($urandom_range(65535, 0)),
                           GAIN_W'($urandom_range(65535, 0)));
      endcase
      stall_pct = (ph % 4 == 0) ? 0 : $urandom_range(70, 10);
      gap_max   = (ph % 3 == 0) ? 0 : $urandom_range(8, 1);
      run_wave(75);
      drain_results();
    end
  endtask

  // Captures one long cycle, closed by a crossing on the sample after a lone
  // negative one, and replays all of it against random input.
  task automatic test_long_cycle();
    set_gains(16'd24576, 16'd20000);
    stall_pct = 10;
    gap_max   = 2;
    settle_to_capture();
    send_sample(-16'sd5);
    repeat (60) send_sample(rand_pos());
    send_sample(-16'sd7);
    send_sample(rand_pos());
    repeat (64) send_sample(rand_any());
    drain_results();
  endtask

  // The result side holds off for a long stretch while requests keep coming,
  // so the pipeline fills and the input stalls.
  task automatic test_output_hold_off();
    set_gains(GAIN_UNITY, 16'd16384);
    stall_pct = 0;
    gap_max   = 0;
    hold_req  = 300;
    run_wave(150);
    drain_results();
  endtask

  // Result side: stalls come in short runs at a rate set by each test, and a
  // long hold-off can be requested on top.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(99, 0) < stall_pct) begin
      stall_run = $urandom_range(4, 1) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_mix.size() == 0) begin
        report_mismatch("unexpected result, out_sample", out_ch.out_sample, 0);
      end else begin
        want_mix = expected_mix.pop_front();
        n_results++;
        if (want_mix.replaying) n_replayed++;
        if (out_ch.out_sample !== want_mix.smp)
          report_mismatch("out_sample", out_ch.out_sample, want_mix.smp);
        if (out_ch.replaying !== want_mix.replaying)
          report_mismatch("replaying", out_ch.replaying, want_mix.replaying);
      end
    end
  end

  initial begin
    cap_count  = 0;
    rep_idx    = 0;
    mode       = MODE_CAPTURE;
    prev_smp   = '0;
    in_gain    = GAIN_UNITY;
    cyc_gain   = GAIN_UNITY;
    burst_left = 0;
    gap_max    = 0;
    stall_pct  = 0;
    stall_run  = 0;
    hold_req   = 0;
    hold_left  = 0;
    n_errors   = 0;
    n_requests = 0;
    n_results  = 0;
    n_replayed = 0;
    n_cycles   = 0;
    n_fills    = 0;
    n_sat      = 0;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.in_sample <= '0;
    cfg_we          <= 1'b0;
    cfg_idx         <= REG_INPUT_GAIN;
    cfg_data        <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_gain_sweep();
    test_long_cycle();
    test_output_hold_off();

    $display("Run covered %0d requests and %0d results, %0d of them mixed with a replay.",
             n_requests, n_results, n_replayed);
    $display("Captured %0d cycles (%0d by a full memory), %0d saturated outputs.",
             n_cycles, n_fills, n_sat);
    if (n_errors == 0 && expected_mix.size() == 0) begin
      $display("** zero_crossing_cycle_replay_core: PASSED **");
    end else begin
      $display("** zero_crossing_cycle_replay_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== zero_crossing_cycle_replay_core.f =====
+incdir+src
src/zccr_pkg.sv
src/zccr_if.sv
src/zccr_capture.sv
src/zccr_mix.sv
src/zero_crossing_cycle_replay_core.sv
test/tb.sv
